// ===== rtl/rbtv_pkg.sv =====
package rbtv_pkg;

    // Normalized magnitudes are brought up to at least this bit position.
    localparam int NORM_TOP = 30;
    // Width of a component magnitude after normalization.
    localparam int MAG_W = 32;
    // Width of the sum of squares of a normalized vector.
    localparam int SQ_W = 64;
    // Width of the integer square root of that sum.
    localparam int ROOT_W = 32;
    // Width of a normalization shift count.
    localparam int SH_W = 5;

    // Left shift that brings the largest magnitude up to bit NORM_TOP.
    function automatic logic [SH_W-1:0] norm_shift(input logic [MAG_W-1:0] mx);
        logic [SH_W-1:0] s;
        s = '0;
        for (int i = 0; i < NORM_TOP; i++)
        begin
            if (mx[i])
            begin
                s = SH_W'(NORM_TOP - i);
            end
        end
        if (|mx[MAG_W-1:NORM_TOP])
        begin
            s = '0;
        end
        return s;
    endfunction

endpackage

// ===== rtl/rbtv_vec_if.sv =====
interface rbtv_vec_if #(
    parameter int W = 24
);
    logic valid;
    logic ready;
    logic signed [W-1:0] from_x;
    logic signed [W-1:0] from_y;
    logic signed [W-1:0] from_z;
    logic signed [W-1:0] to_x;
    logic signed [W-1:0] to_y;
    logic signed [W-1:0] to_z;

    modport source (output valid, from_x, from_y, from_z, to_x, to_y, to_z, input ready);
    modport sink (input valid, from_x, from_y, from_z, to_x, to_y, to_z, output ready);
endinterface

// ===== rtl/rbtv_mat_if.sv =====
interface rbtv_mat_if #(
    parameter int OW = 18
);
    logic valid;
    logic ready;
    logic signed [OW-1:0] r00;
    logic signed [OW-1:0] r01;
    logic signed [OW-1:0] r02;
    logic signed [OW-1:0] r10;
    logic signed [OW-1:0] r11;
    logic signed [OW-1:0] r12;
    logic signed [OW-1:0] r20;
    logic signed [OW-1:0] r21;
    logic signed [OW-1:0] r22;
    logic degenerate;

    modport source (output valid, r00, r01, r02, r10, r11, r12, r20, r21, r22, degenerate,
                    input ready);
    modport sink (input valid, r00, r01, r02, r10, r11, r12, r20, r21, r22, degenerate,
                  output ready);
endinterface

// ===== rtl/rbtv_sqrt_cell.sv =====
module rbtv_sqrt_cell #(
    parameter int LANES = 1,
    parameter int VW = 64,
    parameter int STEP = 0,
    parameter int SBW = 1
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       en,
    input  logic                       valid,
    input  logic [LANES-1:0][VW-1:0]   v,
    input  logic [LANES-1:0][VW-1:0]   root,
    input  logic [SBW-1:0]             sb,
    output logic                       fwd_valid,
    output logic [LANES-1:0][VW-1:0]   fwd_v,
    output logic [LANES-1:0][VW-1:0]   fwd_root,
    output logic [SBW-1:0]             fwd_sb
);
    localparam int BP = VW - 2 - 2 * STEP;
    localparam logic [VW:0] BIT = (VW+1)'(1) << BP;

    logic [LANES-1:0][VW:0]   trial;
    logic [LANES-1:0][VW-1:0] v_next;
    logic [LANES-1:0][VW-1:0] root_next;
    logic [LANES-1:0][VW-1:0] v_reg;
    logic [LANES-1:0][VW-1:0] root_reg;
    logic [SBW-1:0]           sb_reg;
    logic                     valid_reg;

    // One restoring square root step: try the current result bit.
    always_comb
    begin
        for (int l = 0; l < LANES; l++)
        begin
            trial[l] = {1'b0, root[l]} + BIT;
            if ({1'b0, v[l]} >= trial[l])
            begin
                v_next[l]    = v[l] - trial[l][VW-1:0];
                root_next[l] = (root[l] >> 1) + BIT[VW-1:0];
            end
            else
            begin
                v_next[l]    = v[l];
                root_next[l] = root[l] >> 1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            v_reg    <= v_next;
            root_reg <= root_next;
            sb_reg   <= sb;
        end
    end

    assign fwd_valid = valid_reg;
    assign fwd_v     = v_reg;
    assign fwd_root  = root_reg;
    assign fwd_sb    = sb_reg;
endmodule

// ===== rtl/rbtv_div_cell.sv =====
module rbtv_div_cell #(
    parameter int LANES = 1,
    parameter int NW = 8,
    parameter int DW = 4,
    parameter int QW = 4,
    parameter int SHIFT = 0,
    parameter int SBW = 1
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       en,
    input  logic                       valid,
    input  logic [LANES-1:0][NW-1:0]   rem,
    input  logic [LANES-1:0][QW-1:0]   quo,
    input  logic [DW-1:0]              dvs,
    input  logic [SBW-1:0]             sb,
    output logic                       fwd_valid,
    output logic [LANES-1:0][NW-1:0]   fwd_rem,
    output logic [LANES-1:0][QW-1:0]   fwd_quo,
    output logic [DW-1:0]              fwd_dvs,
    output logic [SBW-1:0]             fwd_sb
);
    logic [NW:0]              dsh;
    logic [LANES-1:0]         ge;
    logic [LANES-1:0][NW-1:0] rem_next;
    logic [LANES-1:0][QW-1:0] quo_next;
    logic [LANES-1:0][NW-1:0] rem_reg;
    logic [LANES-1:0][QW-1:0] quo_reg;
    logic [DW-1:0]            dvs_reg;
    logic [SBW-1:0]           sb_reg;
    logic                     valid_reg;

    assign dsh = (NW+1)'(dvs) << SHIFT;

    // One restoring division step: decide quotient bit SHIFT in every lane.
    always_comb
    begin
        for (int l = 0; l < LANES; l++)
        begin
            ge[l]              = ({1'b0, rem[l]} >= dsh);
            rem_next[l]        = ge[l] ? (rem[l] - dsh[NW-1:0]) : rem[l];
            quo_next[l]        = quo[l];
            quo_next[l][SHIFT] = ge[l];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
            dvs_reg <= dvs;
            sb_reg  <= sb;
        end
    end

    assign fwd_valid = valid_reg;
    assign fwd_rem   = rem_reg;
    assign fwd_quo   = quo_reg;
    assign fwd_dvs   = dvs_reg;
    assign fwd_sb    = sb_reg;
endmodule

// ===== rtl/rotation_between_two_vectors.sv =====
// Rotation matrix between two 3-D vectors.
// The vec channel takes a transfer of a source and a destination vector in
// IN_WIDTH-bit two's complement; the mat channel gives one transfer per input
// with the nine entries of the rotation matrix in signed Q1.FRAC_BITS and a
// flag for a zero cross product.
// The block is one pipeline: a row of square root cells for the vector
// lengths, a row of division cells for the unit vectors, a row of square root
// cells for the quaternion scalar and a row of division cells for the matrix.
// One new transfer is taken in every cycle while the pipeline is not held by
// mat.ready, so the sustained rate is one item per cycle. The cell rows work
// one bit per cell: 32 cells for the vector lengths, FRAC_BITS+3 for the
// quaternion norm and FRAC_BITS+1 for each of the two division rows, plus
// stages of plain registers between and around the rows.
// When the receiver holds mat.ready low while a result waits, the whole
// pipeline holds and vec.ready falls; it rises again with the next transfer
// on mat. Reset empties the pipeline; no result is pending after it.
module rotation_between_two_vectors #(
    parameter int IN_WIDTH = 24,
    parameter int FRAC_BITS = 16
) (
    input  logic       clk,
    input  logic       rst_n,
    rbtv_vec_if.sink   vec,
    rbtv_mat_if.source mat
);
    import rbtv_pkg::*;

    localparam int W   = IN_WIDTH;
    localparam int F   = FRAC_BITS;
    localparam int OW  = F + 2;
    localparam int UW  = F + 2;
    localparam int QW  = F + 1;
    localparam int UNW = F + 34;
    localparam int UDW = ROOT_W + 1;
    localparam int PW1 = 2 * F + 3;
    localparam int CW  = 2 * F + 4;
    localparam int XW  = F + 4;
    localparam int H2W = 2 * F + 6;
    localparam int H2N = H2W / 2;
    localparam int WSW = F + 5;
    localparam int PW2 = 2 * F + 10;
    localparam int NW2 = 2 * F + 12;
    localparam int NMW = 2 * F + 13;
    localparam int DW2 = 2 * F + 13;
    localparam int RMW = 3 * F + 14;
    localparam int S1N = SQ_W / 2;

    typedef struct packed {
        logic [2:0][MAG_W-1:0] mag;
        logic [2:0]            neg;
        logic                  zero;
    } uvec_t;

    typedef struct packed {
        logic [2:0] neg;
        logic       zero;
    } usgn_t;

    typedef struct packed {
        logic signed [XW-1:0] x;
        logic signed [XW-1:0] y;
        logic signed [XW-1:0] z;
        logic signed [XW-1:0] dq;
        logic                 degen;
        logic                 dpos;
    } quat_t;

    typedef struct packed {
        logic [8:0] neg;
        logic       degen;
        logic       dpos;
        logic       nzero;
    } msgn_t;

    localparam int UVW = $bits(uvec_t);
    localparam int USW = $bits(usgn_t);
    localparam int QTW = $bits(quat_t);
    localparam int MSW = $bits(msgn_t);

    // Round a Q(2F) value to Q(F), ties away from zero.
    function automatic logic signed [XW-1:0] rnd(input logic signed [CW-1:0] a);
        logic [CW-1:0] m;
        logic [CW-1:0] r;
        m = a[CW-1] ? -a : a;
        r = (m + (CW'(1) << (F - 1))) >> F;
        return a[CW-1] ? -$signed(r[XW-1:0]) : $signed(r[XW-1:0]);
    endfunction

    logic en;
    logic out_v_reg;

    // The pipeline moves whenever the output register is free or being drained.
    assign en        = !out_v_reg || mat.ready;
    assign vec.ready = en;

    // Stage 0: component magnitudes and signs.
    logic [W-1:0]     comp [6];
    logic [W-1:0]     magw [6];
    logic [MAG_W-1:0] mag0_reg [6];
    logic [MAG_W-1:0] mag0_next [6];
    logic [5:0]       neg0_reg;
    logic [5:0]       neg0_next;
    logic             v0_reg;

    assign comp[0] = vec.from_x;
    assign comp[1] = vec.from_y;
    assign comp[2] = vec.from_z;
    assign comp[3] = vec.to_x;
    assign comp[4] = vec.to_y;
    assign comp[5] = vec.to_z;

    always_comb
    begin
        for (int i = 0; i < 6; i++)
        begin
            neg0_next[i] = comp[i][W-1];
            magw[i]      = neg0_next[i] ? (~comp[i] + 1'b1) : comp[i];
            mag0_next[i] = MAG_W'(magw[i]);
        end
    end

    // Stage 1: largest magnitude and normalization shift of each vector.
    uvec_t            u1_next [2];
    uvec_t            u1_reg [2];
    logic [SH_W-1:0]  sh1_next [2];
    logic [SH_W-1:0]  sh1_reg [2];
    logic [MAG_W-1:0] mx1 [2];
    logic             v1_reg;

    always_comb
    begin
        for (int j = 0; j < 2; j++)
        begin
            mx1[j] = mag0_reg[3*j];
            for (int k = 1; k < 3; k++)
            begin
                if (mag0_reg[3*j+k] > mx1[j])
                begin
                    mx1[j] = mag0_reg[3*j+k];
                end
            end
            for (int k = 0; k < 3; k++)
            begin
                u1_next[j].mag[k] = mag0_reg[3*j+k];
                u1_next[j].neg[k] = neg0_reg[3*j+k];
            end
            u1_next[j].zero = (mx1[j] == '0);
            sh1_next[j]     = norm_shift(mx1[j]);
        end
    end

    // Stage 2: normalized magnitudes.
    uvec_t u2_next [2];
    uvec_t u2_reg [2];
    logic  v2_reg;

    always_comb
    begin
        for (int j = 0; j < 2; j++)
        begin
            u2_next[j] = u1_reg[j];
            for (int k = 0; k < 3; k++)
            begin
                u2_next[j].mag[k] = u1_reg[j].mag[k] << sh1_reg[j];
            end
        end
    end

    // Stage 3: squares of the normalized magnitudes.
    logic [SQ_W-1:0] sq3_next [6];
    logic [SQ_W-1:0] sq3_reg [6];
    uvec_t           u3_reg [2];
    logic            v3_reg;

    always_comb
    begin
        for (int i = 0; i < 6; i++)
        begin
            sq3_next[i] = SQ_W'(u2_reg[i/3].mag[i%3]) * SQ_W'(u2_reg[i/3].mag[i%3]);
        end
    end

    // Stage 4: sums of squares.
    logic [SQ_W-1:0] s4_reg [2];
    uvec_t           u4_reg [2];
    logic            v4_reg;

    // Stages 0 to 4 valid bits.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else if (en)
        begin
            v0_reg <= vec.valid;
            v1_reg <= v0_reg;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    // Stages 0 to 4 data.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mag0_reg <= mag0_next;
            neg0_reg <= neg0_next;
            u1_reg   <= u1_next;
            sh1_reg  <= sh1_next;
            u2_reg   <= u2_next;
            sq3_reg  <= sq3_next;
            u3_reg   <= u2_reg;
            for (int j = 0; j < 2; j++)
            begin
                s4_reg[j] <= sq3_reg[3*j] + sq3_reg[3*j+1] + sq3_reg[3*j+2];
            end
            u4_reg   <= u3_reg;
        end
    end

    // Row of square root cells for the two vector lengths.
    logic [1:0][SQ_W-1:0] r1v [0:S1N];
    logic [1:0][SQ_W-1:0] r1r [0:S1N];
    logic [2*UVW-1:0]     r1sb [0:S1N];
    logic                 r1val [0:S1N];

    assign r1v[0]   = {s4_reg[1], s4_reg[0]};
    assign r1r[0]   = '0;
    assign r1sb[0]  = {u4_reg[1], u4_reg[0]};
    assign r1val[0] = v4_reg;

    for (genvar k = 0; k < S1N; k++)
    begin : g_len_sqrt
        rbtv_sqrt_cell #(
            .LANES (2),
            .VW    (SQ_W),
            .STEP  (k),
            .SBW   (2 * UVW)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .valid     (r1val[k]),
            .v         (r1v[k]),
            .root      (r1r[k]),
            .sb        (r1sb[k]),
            .fwd_valid (r1val[k+1]),
            .fwd_v     (r1v[k+1]),
            .fwd_root  (r1r[k+1]),
            .fwd_sb    (r1sb[k+1])
        );
    end

    uvec_t             ue [2];
    logic [ROOT_W-1:0] root1 [2];

    assign {ue[1], ue[0]} = r1sb[S1N];
    assign root1[0] = r1r[S1N][0][ROOT_W-1:0];
    assign root1[1] = r1r[S1N][1][ROOT_W-1:0];

    // Rows of division cells for the unit vectors, one row per vector.
    logic [2:0][UNW-1:0] dur [2][0:QW];
    logic [2:0][QW-1:0]  duq [2][0:QW];
    logic [UDW-1:0]      dud [2][0:QW];
    logic [USW-1:0]      dus [2][0:QW];
    logic                duv [2][0:QW];

    for (genvar j = 0; j < 2; j++)
    begin : g_unit
        usgn_t us0;

        assign us0.neg  = ue[j].neg;
        assign us0.zero = ue[j].zero;

        for (genvar l = 0; l < 3; l++)
        begin : g_num
            assign dur[j][0][l] = (UNW'(ue[j].mag[l]) << (F + 1)) + UNW'(root1[j]);
        end

        assign duq[j][0] = '0;
        assign dud[j][0] = {root1[j], 1'b0};
        assign dus[j][0] = us0;
        assign duv[j][0] = r1val[S1N];

        for (genvar k = 0; k < QW; k++)
        begin : g_step
            rbtv_div_cell #(
                .LANES (3),
                .NW    (UNW),
                .DW    (UDW),
                .QW    (QW),
                .SHIFT (QW - 1 - k),
                .SBW   (USW)
            ) u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .en        (en),
                .valid     (duv[j][k]),
                .rem       (dur[j][k]),
                .quo       (duq[j][k]),
                .dvs       (dud[j][k]),
                .sb        (dus[j][k]),
                .fwd_valid (duv[j][k+1]),
                .fwd_rem   (dur[j][k+1]),
                .fwd_quo   (duq[j][k+1]),
                .fwd_dvs   (dud[j][k+1]),
                .fwd_sb    (dus[j][k+1])
            );
        end
    end

    // Stage U: signed unit vector components.
    logic signed [UW-1:0] ua_next [2][3];
    logic signed [UW-1:0] ua_reg [2][3];
    logic signed [UW-1:0] uq [2][3];
    usgn_t                usg [2];
    logic                 vu_reg;

    always_comb
    begin
        for (int j = 0; j < 2; j++)
        begin
            usg[j] = dus[j][QW];
            for (int l = 0; l < 3; l++)
            begin
                uq[j][l] = $signed({1'b0, duq[j][QW][l]});
                if (usg[j].zero)
                begin
                    ua_next[j][l] = '0;
                end
                else if (usg[j].neg[l])
                begin
                    ua_next[j][l] = -uq[j][l];
                end
                else
                begin
                    ua_next[j][l] = uq[j][l];
                end
            end
        end
    end

    // Stage P1: the nine component products.
    logic signed [PW1-1:0] pr1_next [9];
    logic signed [PW1-1:0] pr1_reg [9];
    logic                  vp1_reg;

    always_comb
    begin
        pr1_next[0] = PW1'(ua_reg[0][1]) * PW1'(ua_reg[1][2]);
        pr1_next[1] = PW1'(ua_reg[0][2]) * PW1'(ua_reg[1][1]);
        pr1_next[2] = PW1'(ua_reg[0][2]) * PW1'(ua_reg[1][0]);
        pr1_next[3] = PW1'(ua_reg[0][0]) * PW1'(ua_reg[1][2]);
        pr1_next[4] = PW1'(ua_reg[0][0]) * PW1'(ua_reg[1][1]);
        pr1_next[5] = PW1'(ua_reg[0][1]) * PW1'(ua_reg[1][0]);
        pr1_next[6] = PW1'(ua_reg[0][0]) * PW1'(ua_reg[1][0]);
        pr1_next[7] = PW1'(ua_reg[0][1]) * PW1'(ua_reg[1][1]);
        pr1_next[8] = PW1'(ua_reg[0][2]) * PW1'(ua_reg[1][2]);
    end

    // Stage P2: cross and dot products in Q(2F).
    logic signed [CW-1:0] c2_reg [3];
    logic signed [CW-1:0] d2_reg;
    logic                 vp2_reg;

    // Stage P3: rounding to Q(F) and the degenerate test.
    quat_t q3_next;
    quat_t q3_reg;
    logic  vp3_reg;

    always_comb
    begin
        q3_next.x     = rnd(c2_reg[0]);
        q3_next.y     = rnd(c2_reg[1]);
        q3_next.z     = rnd(c2_reg[2]);
        q3_next.dq    = rnd(d2_reg);
        q3_next.degen = (c2_reg[0] == '0) && (c2_reg[1] == '0) && (c2_reg[2] == '0);
        q3_next.dpos  = !d2_reg[CW-1];
    end

    // Stage P4: squares of the quaternion vector part and dot.
    logic [H2W-1:0] sq4_reg [4];
    quat_t          q4_reg;
    logic           vp4_reg;

    // Stage P5: their sum.
    logic [H2W-1:0] h2_reg;
    quat_t          q5_reg;
    logic           vp5_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vu_reg  <= 1'b0;
            vp1_reg <= 1'b0;
            vp2_reg <= 1'b0;
            vp3_reg <= 1'b0;
            vp4_reg <= 1'b0;
            vp5_reg <= 1'b0;
        end
        else if (en)
        begin
            vu_reg  <= duv[0][QW] & duv[1][QW];
            vp1_reg <= vu_reg;
            vp2_reg <= vp1_reg;
            vp3_reg <= vp2_reg;
            vp4_reg <= vp3_reg;
            vp5_reg <= vp4_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ua_reg     <= ua_next;
            pr1_reg    <= pr1_next;
            c2_reg[0]  <= CW'(pr1_reg[0]) - CW'(pr1_reg[1]);
            c2_reg[1]  <= CW'(pr1_reg[2]) - CW'(pr1_reg[3]);
            c2_reg[2]  <= CW'(pr1_reg[4]) - CW'(pr1_reg[5]);
            d2_reg     <= CW'(pr1_reg[6]) + CW'(pr1_reg[7]) + CW'(pr1_reg[8]);
            q3_reg     <= q3_next;
            sq4_reg[0] <= H2W'(q3_reg.x) * H2W'(q3_reg.x);
            sq4_reg[1] <= H2W'(q3_reg.y) * H2W'(q3_reg.y);
            sq4_reg[2] <= H2W'(q3_reg.z) * H2W'(q3_reg.z);
            sq4_reg[3] <= H2W'(q3_reg.dq) * H2W'(q3_reg.dq);
            q4_reg     <= q3_reg;
            h2_reg     <= sq4_reg[0] + sq4_reg[1] + sq4_reg[2] + sq4_reg[3];
            q5_reg     <= q4_reg;
        end
    end

    // Row of square root cells for the quaternion norm.
    logic [0:0][H2W-1:0] r2v [0:H2N];
    logic [0:0][H2W-1:0] r2r [0:H2N];
    logic [QTW-1:0]      r2sb [0:H2N];
    logic                r2val [0:H2N];

    assign r2v[0]   = h2_reg;
    assign r2r[0]   = '0;
    assign r2sb[0]  = q5_reg;
    assign r2val[0] = vp5_reg;

    for (genvar k = 0; k < H2N; k++)
    begin : g_norm_sqrt
        rbtv_sqrt_cell #(
            .LANES (1),
            .VW    (H2W),
            .STEP  (k),
            .SBW   (QTW)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .valid     (r2val[k]),
            .v         (r2v[k]),
            .root      (r2r[k]),
            .sb        (r2sb[k]),
            .fwd_valid (r2val[k+1]),
            .fwd_v     (r2v[k+1]),
            .fwd_root  (r2r[k+1]),
            .fwd_sb    (r2sb[k+1])
        );
    end

    // Stage W: scalar part w = h + dq.
    quat_t                qe;
    logic signed [WSW-1:0] w6_next;
    logic signed [WSW-1:0] w6_reg;
    quat_t                q6_reg;
    logic                 vw_reg;

    assign qe      = r2sb[H2N];
    assign w6_next = $signed({1'b0, r2r[H2N][0][F+3:0]}) + WSW'(qe.dq);

    // Stage M1: the ten quaternion products.
    logic signed [PW2-1:0] p7_reg [10];
    logic                  degen7_reg;
    logic                  dpos7_reg;
    logic                  vm1_reg;

    // Stage M2: norm and the nine numerators.
    logic signed [NMW-1:0] num8_next [9];
    logic signed [NMW-1:0] num8_reg [9];
    logic signed [NMW-1:0] e7 [10];
    logic signed [NMW-1:0] n8_sum;
    logic [NW2-1:0]        n8_reg;
    logic                  degen8_reg;
    logic                  dpos8_reg;
    logic                  vm2_reg;

    // Product order: ww, xx, yy, zz, xy, xz, yz, wx, wy, wz.
    always_comb
    begin
        for (int i = 0; i < 10; i++)
        begin
            e7[i] = NMW'(p7_reg[i]);
        end
        n8_sum       = e7[0] + e7[1] + e7[2] + e7[3];
        num8_next[0] = e7[0] + e7[1] - e7[2] - e7[3];
        num8_next[1] = (e7[4] - e7[9]) <<< 1;
        num8_next[2] = (e7[5] + e7[8]) <<< 1;
        num8_next[3] = (e7[4] + e7[9]) <<< 1;
        num8_next[4] = e7[0] - e7[1] + e7[2] - e7[3];
        num8_next[5] = (e7[6] - e7[7]) <<< 1;
        num8_next[6] = (e7[5] - e7[8]) <<< 1;
        num8_next[7] = (e7[6] + e7[7]) <<< 1;
        num8_next[8] = e7[0] - e7[1] - e7[2] + e7[3];
    end

    // Stage M3: magnitudes, clamp and division operands.
    logic [NMW-1:0]      mg9 [9];
    logic [NW2-1:0]      mc9 [9];
    logic [8:0][RMW-1:0] rem9_next;
    logic [8:0][RMW-1:0] rem9_reg;
    logic [DW2-1:0]      d9_reg;
    msgn_t               sb9_next;
    msgn_t               sb9_reg;
    logic                vm3_reg;

    always_comb
    begin
        for (int i = 0; i < 9; i++)
        begin
            sb9_next.neg[i] = num8_reg[i][NMW-1];
            mg9[i]          = num8_reg[i][NMW-1] ? -num8_reg[i] : num8_reg[i];
            mc9[i]          = (mg9[i] >= {1'b0, n8_reg}) ? n8_reg : mg9[i][NW2-1:0];
            rem9_next[i]    = (RMW'(mc9[i]) << (F + 1)) + RMW'(n8_reg);
        end
        sb9_next.degen = degen8_reg;
        sb9_next.dpos  = dpos8_reg;
        sb9_next.nzero = (n8_reg == '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vw_reg  <= 1'b0;
            vm1_reg <= 1'b0;
            vm2_reg <= 1'b0;
            vm3_reg <= 1'b0;
        end
        else if (en)
        begin
            vw_reg  <= r2val[H2N];
            vm1_reg <= vw_reg;
            vm2_reg <= vm1_reg;
            vm3_reg <= vm2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            w6_reg     <= w6_next;
            q6_reg     <= qe;
            p7_reg[0]  <= PW2'(w6_reg) * PW2'(w6_reg);
            p7_reg[1]  <= PW2'(q6_reg.x) * PW2'(q6_reg.x);
            p7_reg[2]  <= PW2'(q6_reg.y) * PW2'(q6_reg.y);
            p7_reg[3]  <= PW2'(q6_reg.z) * PW2'(q6_reg.z);
            p7_reg[4]  <= PW2'(q6_reg.x) * PW2'(q6_reg.y);
            p7_reg[5]  <= PW2'(q6_reg.x) * PW2'(q6_reg.z);
            p7_reg[6]  <= PW2'(q6_reg.y) * PW2'(q6_reg.z);
            p7_reg[7]  <= PW2'(w6_reg) * PW2'(q6_reg.x);
            p7_reg[8]  <= PW2'(w6_reg) * PW2'(q6_reg.y);
            p7_reg[9]  <= PW2'(w6_reg) * PW2'(q6_reg.z);
            degen7_reg <= q6_reg.degen;
            dpos7_reg  <= q6_reg.dpos;
            num8_reg   <= num8_next;
            n8_reg     <= n8_sum[NW2-1:0];
            degen8_reg <= degen7_reg;
            dpos8_reg  <= dpos7_reg;
            rem9_reg   <= rem9_next;
            d9_reg     <= {n8_reg, 1'b0};
            sb9_reg    <= sb9_next;
        end
    end

    // Row of division cells for the nine matrix entries.
    logic [8:0][RMW-1:0] dmr [0:QW];
    logic [8:0][QW-1:0]  dmq [0:QW];
    logic [DW2-1:0]      dmd [0:QW];
    logic [MSW-1:0]      dms [0:QW];
    logic                dmv [0:QW];

    assign dmr[0] = rem9_reg;
    assign dmq[0] = '0;
    assign dmd[0] = d9_reg;
    assign dms[0] = sb9_reg;
    assign dmv[0] = vm3_reg;

    for (genvar k = 0; k < QW; k++)
    begin : g_mat_div
        rbtv_div_cell #(
            .LANES (9),
            .NW    (RMW),
            .DW    (DW2),
            .QW    (QW),
            .SHIFT (QW - 1 - k),
            .SBW   (MSW)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .valid     (dmv[k]),
            .rem       (dmr[k]),
            .quo       (dmq[k]),
            .dvs       (dmd[k]),
            .sb        (dms[k]),
            .fwd_valid (dmv[k+1]),
            .fwd_rem   (dmr[k+1]),
            .fwd_quo   (dmq[k+1]),
            .fwd_dvs   (dmd[k+1]),
            .fwd_sb    (dms[k+1])
        );
    end

    // Output stage: signs and the degenerate cases.
    msgn_t                 me;
    logic signed [OW-1:0]  mq [9];
    logic signed [OW-1:0]  ent_next [9];
    logic signed [OW-1:0]  ent_reg [9];
    logic                  degen_reg;

    assign me = dms[QW];

    always_comb
    begin
        for (int i = 0; i < 9; i++)
        begin
            mq[i] = $signed({1'b0, dmq[QW][i]});
            if (me.degen)
            begin
                if (me.dpos && (i % 4 == 0))
                begin
                    ent_next[i] = OW'(1) << F;
                end
                else
                begin
                    ent_next[i] = '0;
                end
            end
            else if (me.nzero)
            begin
                ent_next[i] = '0;
            end
            else if (me.neg[i])
            begin
                ent_next[i] = -mq[i];
            end
            else
            begin
                ent_next[i] = mq[i];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_v_reg <= 1'b0;
        end
        else if (en)
        begin
            out_v_reg <= dmv[QW];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ent_reg   <= ent_next;
            degen_reg <= me.degen;
        end
    end

    assign mat.valid      = out_v_reg;
    assign mat.r00        = ent_reg[0];
    assign mat.r01        = ent_reg[1];
    assign mat.r02        = ent_reg[2];
    assign mat.r10        = ent_reg[3];
    assign mat.r11        = ent_reg[4];
    assign mat.r12        = ent_reg[5];
    assign mat.r20        = ent_reg[6];
    assign mat.r21        = ent_reg[7];
    assign mat.r22        = ent_reg[8];
    assign mat.degenerate = degen_reg;
endmodule

// ===== bench/tb.sv =====
module tb;

    logic clk;
    logic rst_n;
    int   errors;
    int   matrices_checked;
    int   degenerate_seen;
    bit   sending_done;
    bit   steady_phase;

    rbtv_vec_if #(.W(24)) vec ();
    rbtv_mat_if #(.OW(18)) mat ();

    rotation_between_two_vectors #(.IN_WIDTH(24), .FRAC_BITS(16)) dut
    (
        .clk(clk),
        .rst_n(rst_n),
        .vec(vec.sink),
        .mat(mat.source)
    );

    typedef struct packed
    {
        logic signed [17:0] r00, r01, r02, r10, r11, r12, r20, r21, r22;
        logic               degenerate;
    } rotation_t;

    rotation_t expected_rotations[$];

    // Integer square root, floor.
    function automatic longint unsigned floor_sqrt(input longint unsigned v);
        longint unsigned res;
        longint unsigned b;
        res = 0;
        b = 64'd1 << 62;
        while (b > v)
        begin
            b = b >> 2;
        end
        while (b != 0)
        begin
            if (v >= res + b)
            begin
                v = v - (res + b);
                res = (res >> 1) + b;
            end
            else
            begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return res;
    endfunction

    // Scale a 24-bit vector to unit length in Q16, zero stays zero.
    function automatic void unit_vector(input logic [23:0] cx, cy, cz, output longint u[3]);
        longint unsigned mag[3];
        bit              neg[3];
        logic [23:0]     comp[3];
        longint unsigned mx;
        longint unsigned s;
        longint unsigned r;
        longint unsigned q;
        comp[0] = cx;
        comp[1] = cy;
        comp[2] = cz;
        mx = 0;
        for (int i = 0; i < 3; i++)
        begin
            neg[i] = comp[i][23];
            mag[i] = neg[i] ? (64'h100_0000 - comp[i]) : comp[i];
            if (mag[i] > mx)
            begin
                mx = mag[i];
            end
        end
        if (mx == 0)
        begin
            u[0] = 0;
            u[1] = 0;
            u[2] = 0;
            return;
        end
        while (mx < (64'd1 << 30))
        begin
            mx = mx << 1;
            for (int i = 0; i < 3; i++)
            begin
                mag[i] = mag[i] << 1;
            end
        end
        s = mag[0] * mag[0] + mag[1] * mag[1] + mag[2] * mag[2];
        r = floor_sqrt(s);
        for (int i = 0; i < 3; i++)
        begin
            q = ((mag[i] << 17) + r) / (2 * r);
            u[i] = neg[i] ? -longint'(q) : longint'(q);
        end
    endfunction

    // Round a Q32 product to Q16, ties away from zero.
    function automatic longint to_q16(input longint x);
        longint unsigned m;
        m = (x < 0) ? -x : x;
        m = (m + (64'd1 << 15)) >> 16;
        return (x < 0) ? -longint'(m) : longint'(m);
    endfunction

    // Rounded num / den in Q16, saturated to one.
    function automatic longint ratio_q16(input longint num, input longint unsigned den);
        longint unsigned mag;
        longint unsigned q;
        longint unsigned rem;
        mag = (num < 0) ? -num : num;
        q = 0;
        if (mag >= den)
        begin
            q = 64'd1 << 16;
        end
        else
        begin
            rem = mag;
            for (int i = 0; i < 16; i++)
            begin
                rem = rem << 1;
                q = q << 1;
                if (rem >= den)
                begin
                    rem = rem - den;
                    q = q | 1;
                end
            end
            rem = rem << 1;
            if (rem >= den)
            begin
                q = q + 1;
            end
        end
        return (num < 0) ? -longint'(q) : longint'(q);
    endfunction

    // Work out the rotation matrix for one vector pair.
    function automatic rotation_t predict_rotation(input logic [23:0] fx, fy, fz,
                                                   input logic [23:0] tx, ty, tz);
        longint a[3];
        longint b[3];
        longint c[3];
        longint d;
        longint m[9];
        longint x, y, z, dq, w;
        longint unsigned n;
        rotation_t res;
        unit_vector(fx, fy, fz, a);
        unit_vector(tx, ty, tz, b);
        c[0] = a[1] * b[2] - a[2] * b[1];
        c[1] = a[2] * b[0] - a[0] * b[2];
        c[2] = a[0] * b[1] - a[1] * b[0];
        d = a[0] * b[0] + a[1] * b[1] + a[2] * b[2];
        for (int i = 0; i < 9; i++)
        begin
            m[i] = 0;
        end
        res.degenerate = (c[0] == 0 && c[1] == 0 && c[2] == 0);
        if (res.degenerate)
        begin
            if (d >= 0)
            begin
                m[0] = 65536;
                m[4] = 65536;
                m[8] = 65536;
            end
        end
        else
        begin
            x = to_q16(c[0]);
            y = to_q16(c[1]);
            z = to_q16(c[2]);
            dq = to_q16(d);
            w = longint'(floor_sqrt(x * x + y * y + z * z + dq * dq)) + dq;
            n = w * w + x * x + y * y + z * z;
            if (n != 0)
            begin
                m[0] = ratio_q16(w * w + x * x - y * y - z * z, n);
                m[1] = ratio_q16(2 * (x * y - w * z), n);
                m[2] = ratio_q16(2 * (x * z + w * y), n);
                m[3] = ratio_q16(2 * (x * y + w * z), n);
                m[4] = ratio_q16(w * w - x * x + y * y - z * z, n);
                m[5] = ratio_q16(2 * (y * z - w * x), n);
                m[6] = ratio_q16(2 * (x * z - w * y), n);
                m[7] = ratio_q16(2 * (y * z + w * x), n);
                m[8] = ratio_q16(w * w - x * x - y * y + z * z, n);
            end
        end
        res.r00 = m[0][17:0];
        res.r01 = m[1][17:0];
        res.r02 = m[2][17:0];
        res.r10 = m[3][17:0];
        res.r11 = m[4][17:0];
        res.r12 = m[5][17:0];
        res.r20 = m[6][17:0];
        res.r21 = m[7][17:0];
        res.r22 = m[8][17:0];
        return res;
    endfunction

    // Compare one matrix entry and report a mismatch.
    function automatic void check_entry(input string name, input logic signed [17:0] exp_val,
                                        input logic signed [17:0] got_val);
        if (got_val !== exp_val)
        begin
            $display("%0t: %s exp %0d got %0d", $time, name, exp_val, got_val);
            errors++;
        end
    endfunction

    // Clock.
    initial
    begin
        clk = 1'b0;
    end

    always #10 clk = ~clk;

    // Run limit.
    initial
    begin
        #20000000;
        $display("TEST FAILED");
        $finish;
    end

    // Receiver: random stalls outside the steady phase.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mat.ready <= 1'b0;
        end
        else
        begin
            mat.ready <= steady_phase || ($urandom_range(99) >= 25);
        end
    end

    // Check each result transfer against the oldest expectation.
    always @(posedge clk)
    begin
        rotation_t got;
        rotation_t exp_rot;
        if (rst_n && mat.valid && mat.ready)
        begin
            got = '{mat.r00, mat.r01, mat.r02, mat.r10, mat.r11, mat.r12,
                    mat.r20, mat.r21, mat.r22, mat.degenerate};
            if (expected_rotations.size() == 0)
            begin
                $display("%0t: unexpected result %h", $time, got);
                errors++;
            end
            else
            begin
                exp_rot = expected_rotations.pop_front();
                matrices_checked++;
                if (got.degenerate)
                begin
                    degenerate_seen++;
                end
                check_entry("r00", exp_rot.r00, got.r00);
                check_entry("r01", exp_rot.r01, got.r01);
                check_entry("r02", exp_rot.r02, got.r02);
                check_entry("r10", exp_rot.r10, got.r10);
                check_entry("r11", exp_rot.r11, got.r11);
                check_entry("r12", exp_rot.r12, got.r12);
                check_entry("r20", exp_rot.r20, got.r20);
                check_entry("r21", exp_rot.r21, got.r21);
                check_entry("r22", exp_rot.r22, got.r22);
                if (got.degenerate !== exp_rot.degenerate)
                begin
                    $display("%0t: degenerate exp %0b got %0b", $time,
                             exp_rot.degenerate, got.degenerate);
                    errors++;
                end
            end
        end
    end

    // Send one vector pair, with a random gap first unless in the steady phase.
    task automatic send_pair(input logic [23:0] fx, fy, fz, tx, ty, tz);
        while (!steady_phase && $urandom_range(99) < 25)
        begin
            vec.valid <= 1'b0;
            @(posedge clk);
        end
        vec.valid  <= 1'b1;
        vec.from_x <= fx;
        vec.from_y <= fy;
        vec.from_z <= fz;
        vec.to_x   <= tx;
        vec.to_y   <= ty;
        vec.to_z   <= tz;
        @(posedge clk);
        while (!vec.ready)
        begin
            @(posedge clk);
        end
        expected_rotations.push_back(predict_rotation(fx, fy, fz, tx, ty, tz));
    endtask

    task automatic wait_for_drain();
        vec.valid <= 1'b0;
        while (expected_rotations.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    function automatic logic [23:0] random_component();
        case ($urandom_range(5))
            0: return 24'h800000;
            1: return 24'h7fffff;
            2: return 24'($signed($urandom_range(8)) - 4);
            default: return 24'($urandom);
        endcase
    endfunction

    // Extremes of the fields and each degenerate case.
    task automatic test_directed();
        send_pair(0, 0, 0, 0, 0, 0);
        send_pair(0, 0, 0, 5, 24'(-3), 7);
        send_pair(1, 2, 3, 0, 0, 0);
        send_pair(1, 2, 3, 2, 4, 6);
        send_pair(1, 2, 3, 24'(-2), 24'(-4), 24'(-6));
        send_pair(24'h7fffff, 0, 0, 24'h800000, 0, 0);
        send_pair(24'h800000, 24'h800000, 24'h800000, 24'h7fffff, 24'h7fffff, 24'h7fffff);
        send_pair(24'h800000, 24'h7fffff, 1, 24'(-1), 24'h7fffff, 24'h800000);
        send_pair(1, 0, 0, 0, 1, 0);
        send_pair(0, 1, 0, 0, 0, 1);
        send_pair(0, 0, 1, 1, 0, 0);
        send_pair(24'hffffff, 24'hffffff, 24'hffffff, 1, 1, 1);
        send_pair(24'h555555, 24'haaaaaa, 24'h555555, 24'haaaaaa, 24'h555555, 24'haaaaaa);
        // Near antiparallel: tiny cross product.
        send_pair(24'h7fffff, 1, 0, 24'h800000, 0, 0);
        send_pair(24'h7fffff, 0, 1, 24'h800001, 0, 0);
        send_pair(1000000, 1, 0, 24'(-1000000), 0, 1);
        // Nearly parallel.
        send_pair(24'h7fffff, 1, 0, 24'h7fffff, 0, 0);
    endtask

    // Random vectors, with parallel and antiparallel pairs mixed in.
    task automatic test_random(input int count);
        logic [23:0] f[3];
        logic [23:0] t[3];
        int k;
        for (int n = 0; n < count; n++)
        begin
            for (int i = 0; i < 3; i++)
            begin
                f[i] = random_component();
                t[i] = random_component();
            end
            k = $urandom_range(9);
            if (k == 0)
            begin
                for (int i = 0; i < 3; i++)
                begin
                    f[i] = 24'($signed($urandom_range(2000)) - 1000);
                    t[i] = 24'(f[i] * ($urandom_range(1) ? 3 : -2));
                end
            end
            else if (k == 1)
            begin
                t[0] = 24'(-f[0] + ($urandom_range(2) - 1));
                t[1] = -f[1];
                t[2] = -f[2];
            end
            send_pair(f[0], f[1], f[2], t[0], t[1], t[2]);
        end
    endtask

    // Back to back with no stalls on either side.
    task automatic test_full_rate(input int count);
        steady_phase = 1'b1;
        test_random(count);
        steady_phase = 1'b0;
    endtask

    // Main sequence.
    initial
    begin
        errors = 0;
        matrices_checked = 0;
        degenerate_seen = 0;
        steady_phase = 1'b0;
        rst_n = 1'b0;
        vec.valid = 1'b0;
        vec.from_x = '0;
        vec.from_y = '0;
        vec.from_z = '0;
        vec.to_x = '0;
        vec.to_y = '0;
        vec.to_z = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        // Hold off until the pipeline has emptied.
        wait_for_drain();
        test_random(900);
        test_full_rate(300);
        test_random(700);
        wait_for_drain();
        repeat (150) @(posedge clk);
        $display("Checked %0d rotation matrices, %0d with a zero cross product,",
                 matrices_checked, degenerate_seen);
        $display("over directed, random, stalled and full-rate traffic.");
        if (errors == 0 && expected_rotations.size() == 0)
        begin
            $display("TEST PASSED");
        end
        else
        begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
